// File: hw/rtl/subarray_sum_equals_target_counter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the subarray sum counter
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SUBARRAY_SUM_EQUALS_TARGET_COUNTER_DEFINES_SVH
`define SUBARRAY_SUM_EQUALS_TARGET_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define SSETC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled while reset is high.
`define SSETC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define SSETC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSETC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/ssetc_pkg.sv
// ----------------------------------------------------------------------------
// Subarray sum counter package
// Sizes, table entry type and helper constants shared by the block's files.
// ----------------------------------------------------------------------------
package ssetc_pkg;

  // Element and array limits.
  localparam int ELEM_W      = 16;
  localparam int MAX_LENGTH  = 1024;
  localparam int TABLE_DEPTH = 2048;

  // Field and state widths.
  localparam int TARGET_W = 32;
  localparam int KEY_W    = 26;
  localparam int COUNT_W  = 11;
  localparam int MATCH_W  = 20;
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int SEEN_W   = $clog2(MAX_LENGTH + 1);
  localparam int LKEY_W   = TARGET_W + 2;

  // Generation tag that marks which array an entry belongs to.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  // One hash table entry as stored in the memory.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// File: hw/rtl/ssetc_sample_if.sv
// ----------------------------------------------------------------------------
// Element input channel
// Valid/ready channel that carries one array element per beat.
// ----------------------------------------------------------------------------
interface ssetc_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssetc_pkg::ELEM_W-1:0] element_value;
  logic                               is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

// File: hw/rtl/ssetc_result_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that carries one count result per beat.
// ----------------------------------------------------------------------------
interface ssetc_result_if;
  logic                          valid;
  logic                          ready;
  logic [ssetc_pkg::MATCH_W-1:0] match_count;
  logic                          end_of_array;
  logic                          length_overflow;

  modport source (output valid, output match_count, output end_of_array,
                  output length_overflow, input ready);
  modport sink   (input valid, input match_count, input end_of_array,
                  input length_overflow, output ready);
endinterface

// File: hw/rtl/ssetc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the target sum register.
// ----------------------------------------------------------------------------
interface ssetc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ssetc_pkg::TARGET_W-1:0] target_sum;

  modport source (output valid, output target_sum, input ready);
  modport sink   (input valid, input target_sum, output ready);
endinterface

// File: hw/rtl/subarray_sum_equals_target_counter.sv
// ----------------------------------------------------------------------------
// Subarray sum equals target counter
// Counts contiguous subarrays whose sum equals a target, using a prefix-sum
// hash table with linear probing held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one signed element per beat, is_last closes the array.
//   result returns one beat per element: the running match count, the
//   end-of-array mark and the length overflow mark. cfg writes target_sum and
//   is always ready; the user must write it between arrays (not enforced).
// Sequence:
//   A counted element passes a lookup read, the lookup probe chain and the
//   update probe chain before the next accept; each probe step is one read
//   of the table memory. Its result goes to the output register when the
//   update chain ends. An element past the length limit skips the table.
//   Closing an array adds a step that seeds the entry for sum zero.
// Reset and clearing:
//   After reset a clearing pass sweeps all 2048 entries of the memory, then
//   the seed step follows; no element is accepted meanwhile. Entries carry an
//   8-bit array tag, so the same clearing pass runs again after every 255
//   arrays when the tag wraps.
// Stalls:
//   The result sits in an output register; the next element is accepted
//   while it waits. A further result stalls the block until it is taken.
// ----------------------------------------------------------------------------
`include "subarray_sum_equals_target_counter_defines.svh"

module subarray_sum_equals_target_counter (
  input  logic           clk,
  input  logic           rst,
  ssetc_sample_if.sink   sample,
  ssetc_result_if.source result,
  ssetc_cfg_if.sink      cfg
);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_LREAD = 3'd3;
  localparam logic [2:0] S_LCHK  = 3'd4;
  localparam logic [2:0] S_BCHK  = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  // Largest number of counted elements in one array.
  localparam logic [ssetc_pkg::SEEN_W-1:0] SEEN_LIMIT = ssetc_pkg::SEEN_W'(ssetc_pkg::MAX_LENGTH);

  logic [2:0]                       state, state_next;
  logic [ssetc_pkg::EPOCH_W-1:0]    epoch, epoch_next;
  logic [ssetc_pkg::ADDR_W-1:0]     clr_addr, clr_addr_next;
  logic [ssetc_pkg::KEY_W-1:0]      prefix, prefix_next;
  logic [ssetc_pkg::MATCH_W-1:0]    tally, tally_next;
  logic [ssetc_pkg::SEEN_W-1:0]     seen, seen_next;
  logic [ssetc_pkg::TARGET_W-1:0]   target;
  logic [ssetc_pkg::ADDR_W-1:0]     slot;
  logic [ssetc_pkg::ADDR_W-1:0]     probe, probe_next;
  logic                             item_last, item_last_next;
  logic                             item_over, item_over_next;
  logic                             out_valid;
  logic [ssetc_pkg::MATCH_W-1:0]    out_count;
  logic                             out_end;
  logic                             out_over;

  // Table memory and its ports.
  ssetc_pkg::entry_t                table_mem [ssetc_pkg::TABLE_DEPTH];
  ssetc_pkg::entry_t                rd_entry;
  ssetc_pkg::entry_t                wr_data;
  logic [ssetc_pkg::ADDR_W-1:0]     rd_addr;
  logic [ssetc_pkg::ADDR_W-1:0]     wr_addr;
  logic                             we;

  logic                             out_free;
  logic                             out_load;
  logic                             finish;

  logic [ssetc_pkg::LKEY_W-1:0]     lkey;
  logic [ssetc_pkg::LKEY_W-ssetc_pkg::KEY_W:0] lkey_top;
  logic                             lkey_in_range;
  logic                             probe_last;
  logic                             rd_valid;
  logic                             lk_hit, lk_done;
  logic [ssetc_pkg::COUNT_W-1:0]    lk_hits;
  logic [ssetc_pkg::MATCH_W:0]      match_sum;
  logic                             bp_hit, bp_done;
  logic [ssetc_pkg::COUNT_W-1:0]    bp_count;

  // Handshake outputs.
  assign sample.ready           = (state == S_IDLE);
  assign cfg.ready              = 1'b1;
  assign result.valid           = out_valid;
  assign result.match_count     = out_count;
  assign result.end_of_array    = out_end;
  assign result.length_overflow = out_over;
  assign out_free               = !out_valid || result.ready;

  // Lookup key is the current prefix minus the target, kept wide enough
  // that no difference wraps. Only keys that fit the stored width can match.
  assign lkey = {{(ssetc_pkg::LKEY_W - ssetc_pkg::KEY_W){prefix[ssetc_pkg::KEY_W-1]}}, prefix}
              - {{(ssetc_pkg::LKEY_W - ssetc_pkg::TARGET_W){target[ssetc_pkg::TARGET_W-1]}},
                 target};
  assign lkey_top      = lkey[ssetc_pkg::LKEY_W-1:ssetc_pkg::KEY_W-1];
  assign lkey_in_range = (&lkey_top) || !(|lkey_top);

  // Probe decisions on the entry read in the previous cycle.
  assign probe_last = (probe == ssetc_pkg::ADDR_W'(ssetc_pkg::TABLE_DEPTH - 1));
  assign rd_valid   = (rd_entry.tag == epoch);
  assign lk_hit     = rd_valid && lkey_in_range
                   && (rd_entry.key == lkey[ssetc_pkg::KEY_W-1:0]);
  assign lk_done    = !rd_valid || lk_hit || probe_last;
  assign lk_hits    = lk_hit ? rd_entry.count : '0;
  assign match_sum  = {1'b0, tally} + (ssetc_pkg::MATCH_W + 1)'(lk_hits);
  assign bp_hit     = rd_valid && (rd_entry.key == prefix);
  assign bp_done    = !rd_valid || bp_hit || probe_last;
  assign bp_count   = (rd_entry.count == {ssetc_pkg::COUNT_W{1'b1}})
                    ? rd_entry.count : rd_entry.count + 1'b1;

  // Sequencer: accept, probe for the lookup key, probe and write back the
  // current prefix, then hand the result to the output register.
  always_comb begin
    state_next     = state;
    epoch_next     = epoch;
    clr_addr_next  = clr_addr;
    prefix_next    = prefix;
    tally_next     = tally;
    seen_next      = seen;
    probe_next     = probe + 1'b1;
    item_last_next = item_last;
    item_over_next = item_over;
    rd_addr        = slot + 1'b1;
    we             = 1'b0;
    wr_addr        = slot;
    wr_data        = rd_entry;
    out_load       = 1'b0;
    finish         = 1'b0;

    unique case (state)
      S_CLEAR: begin
        we            = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ssetc_pkg::ADDR_W'(ssetc_pkg::TABLE_DEPTH - 1)) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        // Seed the sum-zero entry at its home slot for the new array.
        we            = 1'b1;
        wr_addr       = '0;
        wr_data.tag   = epoch;
        wr_data.key   = '0;
        wr_data.count = ssetc_pkg::COUNT_W'(1);
        prefix_next   = '0;
        tally_next    = '0;
        seen_next     = '0;
        state_next    = S_IDLE;
      end
      S_IDLE: begin
        if (sample.valid) begin
          item_last_next = sample.is_last;
          if (seen >= ssetc_pkg::SEEN_W'(ssetc_pkg::MAX_LENGTH)) begin
            item_over_next = 1'b1;
            state_next     = S_HOLD;
          end else begin
            item_over_next = 1'b0;
            prefix_next    = prefix
                           + {{(ssetc_pkg::KEY_W - ssetc_pkg::ELEM_W)
                               {sample.element_value[ssetc_pkg::ELEM_W-1]}},
                              sample.element_value};
            seen_next      = seen + 1'b1;
            state_next     = S_LREAD;
          end
        end
      end
      S_LREAD: begin
        rd_addr    = lkey[ssetc_pkg::ADDR_W-1:0];
        probe_next = '0;
        state_next = S_LCHK;
      end
      S_LCHK: begin
        if (lk_done) begin
          tally_next = match_sum[ssetc_pkg::MATCH_W]
                     ? {ssetc_pkg::MATCH_W{1'b1}} : match_sum[ssetc_pkg::MATCH_W-1:0];
          rd_addr    = prefix[ssetc_pkg::ADDR_W-1:0];
          probe_next = '0;
          state_next = S_BCHK;
        end
      end
      S_BCHK: begin
        if (bp_done) begin
          // A full probe chain without a free slot leaves the table as is.
          we            = !rd_valid || bp_hit;
          wr_data.tag   = epoch;
          wr_data.key   = prefix;
          wr_data.count = bp_hit ? bp_count : ssetc_pkg::COUNT_W'(1);
          if (out_free) begin
            out_load = 1'b1;
            finish   = 1'b1;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          finish   = 1'b1;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // Closing an array moves to a new tag; a wrapped tag needs a full sweep.
    if (finish) begin
      if (item_last) begin
        if (epoch == ssetc_pkg::EPOCH_MAX) begin
          epoch_next = ssetc_pkg::EPOCH_W'(1);
          state_next = S_CLEAR;
        end else begin
          epoch_next = epoch + 1'b1;
          state_next = S_INIT;
        end
      end else begin
        state_next = S_IDLE;
      end
    end
  end

  // Control and running state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      epoch     <= ssetc_pkg::EPOCH_W'(1);
      clr_addr  <= '0;
      prefix    <= '0;
      tally     <= '0;
      seen      <= '0;
      target    <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      epoch    <= epoch_next;
      clr_addr <= clr_addr_next;
      prefix   <= prefix_next;
      tally    <= tally_next;
      seen     <= seen_next;
      if (cfg.valid) begin
        target <= cfg.target_sum;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers; slot always names the entry held in rd_entry.
  always_ff @(posedge clk) begin
    slot      <= rd_addr;
    probe     <= probe_next;
    item_last <= item_last_next;
    item_over <= item_over_next;
    if (out_load) begin
      out_count <= tally;
      out_end   <= item_last;
      out_over  <= item_over;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_entry <= table_mem[rd_addr];
  end

  // Checks on the sequencer's own bookkeeping.
  `SSETC_ASSERT_NEXT(a_tally_grows, clk, rst, (state != S_INIT), (tally >= $past(tally)))
  `SSETC_ASSERT_IMPL(a_seen_bound, clk, rst, 1'b1, (seen <= SEEN_LIMIT))
  `SSETC_ASSERT_IMPL(a_epoch_live, clk, rst, 1'b1, (epoch != '0))
  `SSETC_ASSERT_IMPL(a_load_free, clk, rst, out_load, out_free)

endmodule
